/* rtl/icfe_pkg.sv */
`timescale 1ns / 1ps

package icfe_pkg;

   // frame geometry
   localparam int FRAME_BYTES = 25;
   localparam int ADDR_W      = $clog2(FRAME_BYTES);
   localparam int VAR_COUNT   = 5;
   localparam int VAR_IDX_W   = $clog2(VAR_COUNT);

   localparam logic [ADDR_W-1:0] LAST_BYTE = ADDR_W'(FRAME_BYTES - 1);

   // frame bytes that depend on the start beat
   localparam logic [ADDR_W-1:0] POS_MODE  = ADDR_W'(12);
   localparam logic [ADDR_W-1:0] POS_TEMP  = ADDR_W'(16);
   localparam logic [ADDR_W-1:0] POS_FAN   = ADDR_W'(17);
   localparam logic [ADDR_W-1:0] POS_SWING = ADDR_W'(18);
   localparam logic [ADDR_W-1:0] POS_SUM   = ADDR_W'(24);

   localparam logic [ADDR_W-1:0] VAR_POS [VAR_COUNT] = '{
      POS_MODE, POS_TEMP, POS_FAN, POS_SWING, POS_SUM
   };

   // fixed frame template
   localparam logic [7:0] TEMPLATE [FRAME_BYTES] = '{
      8'h11, 8'hDA, 8'h17, 8'h48, 8'h04, 8'h00, 8'h4E, 8'h11, 8'hDA, 8'h17,
      8'h48, 8'h00, 8'h73, 8'h00, 8'h21, 8'h00, 8'h00, 8'h1C, 8'h50, 8'h00,
      8'h20, 8'h00, 8'h00, 8'h00, 8'h6A
   };

   // mode codes
   localparam logic [7:0] MODE_OFF  = 8'h00;
   localparam logic [7:0] MODE_COOL = 8'h73;
   localparam logic [7:0] MODE_HEAT = 8'h51;
   localparam logic [7:0] MODE_DRY  = 8'h47;
   localparam logic [7:0] MODE_AUTO = 8'h43;
   localparam logic [7:0] MODE_FAN  = 8'h40;

   localparam logic [2:0] MSEL_OFF  = 3'd0;
   localparam logic [2:0] MSEL_COOL = 3'd1;
   localparam logic [2:0] MSEL_HEAT = 3'd2;
   localparam logic [2:0] MSEL_DRY  = 3'd3;
   localparam logic [2:0] MSEL_AUTO = 3'd4;
   localparam logic [2:0] MSEL_FAN  = 3'd5;

   // fan codes
   localparam logic [7:0] FAN_CODE [4] = '{8'h0F, 8'h1F, 8'h3F, 8'h5F};

   // swing codes
   localparam logic [7:0] SWING_OFF  = 8'h20;
   localparam logic [7:0] SWING_VERT = 8'h52;
   localparam logic [7:0] SWING_BOTH = 8'h5F;

   localparam logic [1:0] SSEL_VERT = 2'd1;
   localparam logic [1:0] SSEL_BOTH = 2'd2;

   // temperature limits
   localparam logic [7:0] TEMP_MIN    = 8'd16;
   localparam logic [7:0] TEMP_MAX    = 8'd30;
   localparam logic [7:0] TEMP_OFFSET = 8'd18;

   // opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_NEXT  = 1'b1;

   // register map
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] REG_HEADER_MARK   = 3'd0;
   localparam logic [2:0] REG_HEADER_SPACE  = 3'd1;
   localparam logic [2:0] REG_BIT_MARK      = 3'd2;
   localparam logic [2:0] REG_ONE_SPACE     = 3'd3;
   localparam logic [2:0] REG_ZERO_SPACE    = 3'd4;
   localparam logic [2:0] REG_TRAILER_SPACE = 3'd5;

   localparam logic [15:0] HEADER_MARK_RST   = 16'd3500;
   localparam logic [15:0] HEADER_SPACE_RST  = 16'd1700;
   localparam logic [15:0] BIT_MARK_RST      = 16'd430;
   localparam logic [15:0] ONE_SPACE_RST     = 16'd1300;
   localparam logic [15:0] ZERO_SPACE_RST    = 16'd420;
   localparam logic [15:0] TRAILER_SPACE_RST = 16'd8000;

   typedef struct packed {
      logic       opcode;
      logic [2:0] mode_sel;
      logic [7:0] temperature_deg;
      logic [1:0] fan_sel;
      logic [1:0] swing_sel;
   } req_type;

   typedef struct packed {
      logic [15:0] mark_us;
      logic [15:0] space_us;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] header_mark_us;
      logic [15:0] header_space_us;
      logic [15:0] bit_mark_us;
      logic [15:0] one_space_us;
      logic [15:0] zero_space_us;
      logic [15:0] trailer_space_us;
   } timing_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } ram_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } ram_rd_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'b001,
      PH_DATA    = 3'b010,
      PH_TRAILER = 3'b100
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER,
      KIND_DATA,
      KIND_TRAILER
   } kind_type;

   // byte position written from the start beat
   function automatic logic is_var_pos(input logic [ADDR_W-1:0] idx);
      return (idx inside {POS_MODE, POS_TEMP, POS_FAN, POS_SWING, POS_SUM});
   endfunction

   // template byte, zero beyond the frame
   function automatic logic [7:0] template_byte(input logic [ADDR_W-1:0] idx);
      logic [7:0] b;
      b = 8'h00;
      for (int i = 0; i < FRAME_BYTES; i++) begin
         if (idx == ADDR_W'(i)) begin
            b = TEMPLATE[i];
         end
      end
      return b;
   endfunction

   // sum of the template bytes that never change
   function automatic logic [7:0] fixed_sum();
      logic [7:0] s;
      s = 8'h00;
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
         if (!is_var_pos(ADDR_W'(i))) begin
            s = s + TEMPLATE[i];
         end
      end
      return s;
   endfunction

   localparam logic [7:0] FIXED_SUM = fixed_sum();

endpackage

/* rtl/icfe_ram.sv */
`timescale 1ns / 1ps

module icfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, held when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/icfe_frame_writer.sv */
`timescale 1ns / 1ps

module icfe_frame_writer (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  icfe_pkg::req_type   req_data,
   output icfe_pkg::ram_wr_type wr
);

   import icfe_pkg::*;

   logic [7:0]           bytes_ff [VAR_COUNT];
   logic [7:0]           bytes_in [VAR_COUNT];
   logic [VAR_IDX_W-1:0] idx_ff, idx_in;
   logic                 busy_ff, busy_in;

   logic [7:0] mode_code;
   logic [7:0] temp_clamped;
   logic [7:0] temp_code;
   logic [7:0] fan_code;
   logic [7:0] swing_code;
   logic [7:0] sum_code;

   // mode byte
   always_comb begin
      case (req_data.mode_sel)
         MSEL_OFF:  mode_code = MODE_OFF;
         MSEL_COOL: mode_code = MODE_COOL;
         MSEL_HEAT: mode_code = MODE_HEAT;
         MSEL_DRY:  mode_code = MODE_DRY;
         MSEL_AUTO: mode_code = MODE_AUTO;
         MSEL_FAN:  mode_code = MODE_FAN;
         default:   mode_code = MODE_OFF;
      endcase
   end

   // temperature byte: twice the clamped value less the offset
   always_comb begin
      if (req_data.temperature_deg < TEMP_MIN) begin
         temp_clamped = TEMP_MIN;
      end else if (req_data.temperature_deg > TEMP_MAX) begin
         temp_clamped = TEMP_MAX;
      end else begin
         temp_clamped = req_data.temperature_deg;
      end
      temp_code = {temp_clamped[6:0], 1'b0} - TEMP_OFFSET;
   end

   // fan and swing bytes
   always_comb begin
      fan_code = FAN_CODE[req_data.fan_sel];
      case (req_data.swing_sel)
         SSEL_VERT: swing_code = SWING_VERT;
         SSEL_BOTH: swing_code = SWING_BOTH;
         default:   swing_code = SWING_OFF;
      endcase
   end

   // checksum over every frame byte but the checksum byte itself
   assign sum_code = FIXED_SUM + mode_code + temp_code + fan_code + swing_code;

   // latch the bytes and step through the write sequence
   always_comb begin
      bytes_in = bytes_ff;
      idx_in   = idx_ff;
      busy_in  = busy_ff;
      if (start) begin
         bytes_in[0] = mode_code;
         bytes_in[1] = temp_code;
         bytes_in[2] = fan_code;
         bytes_in[3] = swing_code;
         bytes_in[4] = sum_code;
         idx_in      = '0;
         busy_in     = 1'b1;
      end else if (busy_ff) begin
         if (idx_ff == VAR_IDX_W'(VAR_COUNT - 1)) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      idx_ff   <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign wr.en   = busy_ff;
   assign wr.addr = VAR_POS[idx_ff];
   assign wr.data = bytes_ff[idx_ff];

endmodule

/* rtl/icfe_pulse_pipe.sv */
`timescale 1ns / 1ps

module icfe_pulse_pipe (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_opcode,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output icfe_pkg::rsp_type    rsp_data,
   input  icfe_pkg::timing_type timing,
   output icfe_pkg::ram_rd_type rd,
   input  logic [7:0]           rd_data
);

   import icfe_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [ADDR_W-1:0] byte_pos_ff, byte_pos_in;
   logic [2:0]        bit_pos_ff, bit_pos_in;

   logic              s1_valid_ff, s1_valid_in;
   kind_type          s1_kind_ff, s1_kind_in;
   logic [ADDR_W-1:0] s1_byte_ff, s1_byte_in;
   logic [2:0]        s1_bit_ff, s1_bit_in;
   logic              s1_ram_ff, s1_ram_in;

   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;

   logic accept;
   logic out_free;
   logic s1_adv;
   logic produce;
   logic [7:0] cur_byte;
   logic       cur_bit;

   // handshake: the output register parts the two sides
   assign out_free  = !out_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   // frame position and phase, read issued when a data beat is accepted
   always_comb begin
      phase_in    = phase_ff;
      byte_pos_in = byte_pos_ff;
      bit_pos_in  = bit_pos_ff;
      s1_kind_in  = s1_kind_ff;
      s1_byte_in  = s1_byte_ff;
      s1_bit_in   = s1_bit_ff;
      s1_ram_in   = s1_ram_ff;
      produce     = 1'b0;
      rd.en       = 1'b0;
      rd.addr     = byte_pos_ff;
      if (accept) begin
         if (req_opcode == OP_START) begin
            produce     = 1'b1;
            s1_kind_in  = KIND_HEADER;
            phase_in    = PH_DATA;
            byte_pos_in = '0;
            bit_pos_in  = 3'd7;
         end else begin
            case (phase_ff)
               PH_DATA: begin
                  produce    = 1'b1;
                  rd.en      = 1'b1;
                  s1_kind_in = KIND_DATA;
                  s1_byte_in = byte_pos_ff;
                  s1_bit_in  = bit_pos_ff;
                  s1_ram_in  = is_var_pos(byte_pos_ff);
                  if (bit_pos_ff == 3'd0) begin
                     bit_pos_in = 3'd7;
                     if (byte_pos_ff == LAST_BYTE) begin
                        byte_pos_in = '0;
                        phase_in    = PH_TRAILER;
                     end else begin
                        byte_pos_in = byte_pos_ff + 1'b1;
                     end
                  end else begin
                     bit_pos_in = bit_pos_ff - 1'b1;
                  end
               end
               PH_TRAILER: begin
                  produce    = 1'b1;
                  s1_kind_in = KIND_TRAILER;
                  phase_in   = PH_IDLE;
               end
               default: begin
                  produce = 1'b0;
               end
            endcase
         end
      end
   end

   // read stage occupancy
   always_comb begin
      if (accept && produce) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // pick the bit and form the pulse pair
   always_comb begin
      cur_byte = s1_ram_ff ? rd_data : template_byte(s1_byte_ff);
      cur_bit  = cur_byte[s1_bit_ff];
      case (s1_kind_ff)
         KIND_HEADER: begin
            out_in.mark_us  = timing.header_mark_us;
            out_in.space_us = timing.header_space_us;
            out_in.last     = 1'b0;
         end
         KIND_DATA: begin
            out_in.mark_us  = timing.bit_mark_us;
            out_in.space_us = cur_bit ? timing.one_space_us : timing.zero_space_us;
            out_in.last     = 1'b0;
         end
         default: begin
            out_in.mark_us  = timing.bit_mark_us;
            out_in.space_us = timing.trailer_space_us;
            out_in.last     = 1'b1;
         end
      endcase
   end

   // output register occupancy
   always_comb begin
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         byte_pos_ff  <= '0;
         bit_pos_ff   <= 3'd7;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         byte_pos_ff  <= byte_pos_in;
         bit_pos_ff   <= bit_pos_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff <= s1_kind_in;
      s1_byte_ff <= s1_byte_in;
      s1_bit_ff  <= s1_bit_in;
      s1_ram_ff  <= s1_ram_in;
      if (s1_adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

/* rtl/ir_climate_frame_encoder_core.sv */
`timescale 1ns / 1ps

// climate remote frame encoder, pulse-distance ir timing
// req channel: a start beat (opcode 0) builds a new 25-byte frame from mode,
// temperature, fan and swing and answers with the header mark/space pair;
// each next beat (opcode 1) answers with one data bit pair, msb first from
// byte 0, then the trailer pair with last set; a next beat while idle is
// consumed with no answer, and a start beat mid-frame restarts the frame
// rsp channel: one mark/space beat in microseconds per answered req beat
// csr port: six 16-bit timing registers at byte addresses 0..20, step 4
// the req beat passes the read stage and then the output register, whose
// valid drives rsp_valid; a stalled result holds it in the read stage
// throughput: one req beat per cycle while req_ready is high; each data beat
// makes one read of the frame ram, and the five start-dependent bytes are
// written into it one after another after a start beat
// reset: timing registers take their defaults, the sequencer goes idle;
// the frame ram is not cleared, a start beat always fills it first
// stall: while rsp_ready is low the result and the read stage hold, and
// req_ready drops once both are full
module ir_climate_frame_encoder_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  icfe_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output icfe_pkg::rsp_type                rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [icfe_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   import icfe_pkg::*;

   timing_type timing_ff, timing_in;
   ram_wr_type wr;
   ram_rd_type rd;
   logic [7:0] rd_data;
   logic       csr_write;
   logic [2:0] csr_index;
   logic       start_fire;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      timing_in = timing_ff;
      if (csr_write) begin
         case (csr_index)
            REG_HEADER_MARK:   timing_in.header_mark_us   = csr_pwdata[15:0];
            REG_HEADER_SPACE:  timing_in.header_space_us  = csr_pwdata[15:0];
            REG_BIT_MARK:      timing_in.bit_mark_us      = csr_pwdata[15:0];
            REG_ONE_SPACE:     timing_in.one_space_us     = csr_pwdata[15:0];
            REG_ZERO_SPACE:    timing_in.zero_space_us    = csr_pwdata[15:0];
            REG_TRAILER_SPACE: timing_in.trailer_space_us = csr_pwdata[15:0];
            default:           timing_in = timing_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_HEADER_MARK:   csr_prdata = {16'h0000, timing_ff.header_mark_us};
         REG_HEADER_SPACE:  csr_prdata = {16'h0000, timing_ff.header_space_us};
         REG_BIT_MARK:      csr_prdata = {16'h0000, timing_ff.bit_mark_us};
         REG_ONE_SPACE:     csr_prdata = {16'h0000, timing_ff.one_space_us};
         REG_ZERO_SPACE:    csr_prdata = {16'h0000, timing_ff.zero_space_us};
         REG_TRAILER_SPACE: csr_prdata = {16'h0000, timing_ff.trailer_space_us};
         default:           csr_prdata = 32'h0000_0000;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.header_mark_us   <= HEADER_MARK_RST;
         timing_ff.header_space_us  <= HEADER_SPACE_RST;
         timing_ff.bit_mark_us      <= BIT_MARK_RST;
         timing_ff.one_space_us     <= ONE_SPACE_RST;
         timing_ff.zero_space_us    <= ZERO_SPACE_RST;
         timing_ff.trailer_space_us <= TRAILER_SPACE_RST;
      end else begin
         timing_ff <= timing_in;
      end
   end

   // start beat taken
   assign start_fire = req_valid && req_ready && (req_data.opcode == OP_START);

   icfe_frame_writer u_writer (
      .clock    (clock),
      .reset    (reset),
      .start    (start_fire),
      .req_data (req_data),
      .wr       (wr)
   );

   icfe_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_BYTES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (rd.en),
      .rd_addr (rd.addr),
      .rd_data (rd_data)
   );

   icfe_pulse_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_data.opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .timing     (timing_ff),
      .rd         (rd),
      .rd_data    (rd_data)
   );

`ifndef ASSERT_OFF
   // a start beat always launches the frame byte writes
   a_start_writes: assert property (@(posedge clock) disable iff (reset)
      start_fire |=> wr.en)
      else $error("start beat did not launch frame writes");

   // input stalls only behind a stalled result
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("req_ready low without a stalled result");

   // ram writes only touch start-dependent bytes
   a_write_pos: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (wr.addr == POS_MODE || wr.addr == POS_TEMP || wr.addr == POS_FAN ||
                 wr.addr == POS_SWING || wr.addr == POS_SUM))
      else $error("frame write to a fixed template byte");
`endif

endmodule
